>>> hdl/idr_pkg.sv
package idr_pkg;

   localparam int DEPTH_LOG2 = 10;
   localparam int VALUE_BITS = 32;
   localparam int PTR_BITS   = 32;
   localparam int DEPTH      = 1 << DEPTH_LOG2;
   localparam int FILL_BITS  = DEPTH_LOG2 + 1;
   localparam int CAPL_BITS  = 4;
   localparam int PRE_BITS   = 11;
   localparam int ACT_BITS   = 3;
   localparam int REQ_BITS   = VALUE_BITS + PTR_BITS;
   localparam int RSP_RAW    = VALUE_BITS + FILL_BITS;
   localparam int RSP_BITS   = ((RSP_RAW + 7) / 8) * 8;
   localparam int CSR_BITS   = PRE_BITS;

   typedef enum logic [ACT_BITS-1:0] {
      ACT_PUSH_HEAD = 3'd0,
      ACT_POP_HEAD  = 3'd1,
      ACT_PUSH_TAIL = 3'd2,
      ACT_POP_TAIL  = 3'd3,
      ACT_PEEK      = 3'd4,
      ACT_REINIT    = 3'd5
   } action_type;

   typedef enum logic [0:0] {
      REG_CAP_LOG2 = 1'b0,
      REG_PREFILL  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL
   } state_type;

endpackage

>>> hdl/idr_ram.sv
module idr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/index_deque_ring.sv
// Double-ended ring queue of 32-bit values in a 1024-entry store, with push
// and pop at head and tail, peek at any pointer value and reinit with an
// optional 0, 1, 2, ... prefill. One request gives one response. Push,
// reinit without prefill, refused operations and unused actions answer
// straight from the idle state, so with rsp_tready high such requests are
// taken every cycle. A successful pop and a peek pass through ST_READ, as
// the store's read data is registered. A reinit with prefill walks ST_FILL,
// as the store's single write port loads one value a cycle. The store is
// not cleared after reset; no read of an unwritten entry is made by a
// correct use of the queue. Write csr_ registers only while the queue is
// idle; csr_ready is always high.
module index_deque_ring (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // value_in [31:0], peek_index [63:32]
   input  logic [idr_pkg::REQ_BITS-1:0]    req_tdata,
   // action [2:0]
   input  logic [idr_pkg::ACT_BITS-1:0]    req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // value_out [31:0], fill_count [42:32], zero [47:43]
   output logic [idr_pkg::RSP_BITS-1:0]    rsp_tdata,
   // ok [0]
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_addr,
   input  logic [idr_pkg::CSR_BITS-1:0]    csr_data
);

   import idr_pkg::*;

   state_type               state_ff, state_in;
   logic [PTR_BITS-1:0]     head_ff, head_in;
   logic [PTR_BITS-1:0]     tail_ff, tail_in;
   logic [CAPL_BITS-1:0]    cap_log2_ff;
   logic [PRE_BITS-1:0]     prefill_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [FILL_BITS-1:0]    rsp_fill_ff, rsp_fill_in;
   logic [FILL_BITS-1:0]    pend_fill_ff, pend_fill_in;
   logic [DEPTH_LOG2-1:0]   fill_idx_ff, fill_idx_in;

   logic [CAPL_BITS-1:0]    lg;
   logic [FILL_BITS-1:0]    size;
   logic [DEPTH_LOG2-1:0]   mask;
   logic [PTR_BITS-1:0]     count;
   logic [PTR_BITS-1:0]     count_next;
   logic [FILL_BITS-1:0]    pre_n;
   logic [FILL_BITS-1:0]    fill_pos;
   logic                    accept;
   logic                    load_now;
   logic [VALUE_BITS-1:0]   value_now;
   logic                    ok_now;
   logic [VALUE_BITS-1:0]   value_in;
   logic [PTR_BITS-1:0]     peek_index;
   action_type              action;

   logic                    wr_en;
   logic [DEPTH_LOG2-1:0]   wr_addr;
   logic [VALUE_BITS-1:0]   wr_data;
   logic                    rd_en;
   logic [DEPTH_LOG2-1:0]   rd_addr;
   logic [VALUE_BITS-1:0]   rd_data;

   idr_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign value_in   = req_tdata[VALUE_BITS-1:0];
   assign peek_index = req_tdata[REQ_BITS-1:VALUE_BITS];
   assign action     = action_type'(req_tuser);

   assign lg    = (cap_log2_ff > CAPL_BITS'(DEPTH_LOG2)) ? CAPL_BITS'(DEPTH_LOG2) : cap_log2_ff;
   assign size  = FILL_BITS'(1) << lg;
   assign mask  = DEPTH_LOG2'(size - FILL_BITS'(1));
   assign count = head_ff - tail_ff - PTR_BITS'(1);
   assign pre_n = (FILL_BITS'(prefill_ff) > size) ? size : FILL_BITS'(prefill_ff);

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign fill_pos   = FILL_BITS'(fill_idx_ff) + FILL_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_fill_in  = rsp_fill_ff;
      pend_fill_in = pend_fill_ff;
      fill_idx_in  = fill_idx_ff;
      load_now     = 1'b0;
      value_now    = '0;
      ok_now       = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_now = 1'b1;
               case (action)
                  ACT_PUSH_HEAD: begin
                     if (count < PTR_BITS'(size)) begin
                        wr_en   = 1'b1;
                        wr_addr = head_ff[DEPTH_LOG2-1:0] & mask;
                        wr_data = value_in;
                        head_in = head_ff + PTR_BITS'(1);
                        ok_now  = 1'b1;
                     end
                  end
                  ACT_PUSH_TAIL: begin
                     if (count < PTR_BITS'(size)) begin
                        wr_en   = 1'b1;
                        wr_addr = tail_ff[DEPTH_LOG2-1:0] & mask;
                        wr_data = value_in;
                        tail_in = tail_ff - PTR_BITS'(1);
                        ok_now  = 1'b1;
                     end
                  end
                  ACT_POP_HEAD: begin
                     if (count != '0) begin
                        head_in  = head_ff - PTR_BITS'(1);
                        rd_en    = 1'b1;
                        rd_addr  = head_in[DEPTH_LOG2-1:0] & mask;
                        load_now = 1'b0;
                        state_in = ST_READ;
                     end else begin
                        value_now = '1;
                     end
                  end
                  ACT_POP_TAIL: begin
                     if (count != '0) begin
                        tail_in  = tail_ff + PTR_BITS'(1);
                        rd_en    = 1'b1;
                        rd_addr  = tail_in[DEPTH_LOG2-1:0] & mask;
                        load_now = 1'b0;
                        state_in = ST_READ;
                     end else begin
                        value_now = '1;
                     end
                  end
                  ACT_PEEK: begin
                     rd_en    = 1'b1;
                     rd_addr  = peek_index[DEPTH_LOG2-1:0] & mask;
                     load_now = 1'b0;
                     state_in = ST_READ;
                  end
                  ACT_REINIT: begin
                     head_in     = PTR_BITS'(pre_n) + PTR_BITS'(1);
                     tail_in     = '0;
                     ok_now      = 1'b1;
                     fill_idx_in = '0;
                     if (pre_n != '0) begin
                        load_now = 1'b0;
                        state_in = ST_FILL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            rsp_ok_in    = 1'b1;
            rsp_fill_in  = pend_fill_ff;
            state_in     = ST_IDLE;
         end
         ST_FILL: begin
            wr_en       = 1'b1;
            wr_addr     = fill_pos[DEPTH_LOG2-1:0] & mask;
            wr_data     = VALUE_BITS'(fill_idx_ff);
            fill_idx_in = fill_pos[DEPTH_LOG2-1:0];
            if (fill_pos == pend_fill_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_ok_in    = 1'b1;
               rsp_fill_in  = pend_fill_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      count_next = head_in - tail_in - PTR_BITS'(1);
      if (accept) begin
         pend_fill_in = count_next[FILL_BITS-1:0];
      end
      if (load_now) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = value_now;
         rsp_ok_in    = ok_now;
         rsp_fill_in  = count_next[FILL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= PTR_BITS'(1);
         tail_ff      <= '0;
         cap_log2_ff  <= CAPL_BITS'(DEPTH_LOG2);
         prefill_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_addr))
               REG_CAP_LOG2: cap_log2_ff <= csr_data[CAPL_BITS-1:0];
               REG_PREFILL:  prefill_ff  <= csr_data[PRE_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_fill_ff  <= rsp_fill_in;
      pend_fill_ff <= pend_fill_in;
      fill_idx_ff  <= fill_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_fill_ff, rsp_value_ff});
   assign rsp_tuser  = rsp_ok_ff;

endmodule

>>> hdl/idr_checker.sv
module idr_props (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [idr_pkg::RSP_BITS-1:0]    rsp_tdata,
   input  logic                            rsp_tuser
);

   import idr_pkg::*;

   logic [VALUE_BITS-1:0] value_out;
   logic [FILL_BITS-1:0]  fill_count;

   assign value_out  = rsp_tdata[VALUE_BITS-1:0];
   assign fill_count = rsp_tdata[RSP_RAW-1:VALUE_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_refused_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (value_out == '0) || (value_out == '1))
      else $error("refused response carries a value");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fill_count <= FILL_BITS'(DEPTH))
      else $error("fill count beyond store depth");

   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response straight after reset");

endmodule

bind index_deque_ring idr_props u_idr_props (.*);

>>> sim/idr_checker.sv
`timescale 1ns / 1ps

module idr_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [idr_pkg::REQ_BITS-1:0]    req_tdata,
   input  logic [idr_pkg::ACT_BITS-1:0]    req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [idr_pkg::RSP_BITS-1:0]    rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic                            csr_addr,
   input  logic [idr_pkg::CSR_BITS-1:0]    csr_data,
   output int                              fail_count,
   output int                              answers_due,
   output logic [idr_pkg::DEPTH-1:0]       written_map,
   output logic [idr_pkg::PTR_BITS-1:0]    head_ptr_q,
   output logic [idr_pkg::PTR_BITS-1:0]    tail_ptr_q,
   output logic [idr_pkg::CAPL_BITS-1:0]   cap_log2_q
);

   import idr_pkg::*;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  ok;
      logic [FILL_BITS-1:0]  fill;
   } ring_answer_type;

   logic [VALUE_BITS-1:0] entry_mem [DEPTH];
   logic [PRE_BITS-1:0]   prefill_q;
   ring_answer_type       pending_answers [$];

   task automatic put_entry(input logic [PTR_BITS-1:0] pos, input logic [VALUE_BITS-1:0] v);
      entry_mem[DEPTH_LOG2'(pos)] = v;
      written_map[DEPTH_LOG2'(pos)] = 1'b1;
   endtask

   task automatic apply_deque_op(
      input  logic [ACT_BITS-1:0]   act,
      input  logic [VALUE_BITS-1:0] vin,
      input  logic [PTR_BITS-1:0]   pidx,
      output ring_answer_type       ans
   );
      logic [CAPL_BITS-1:0] lg;
      logic [PTR_BITS-1:0]  room;
      logic [PTR_BITS-1:0]  mask;
      logic [PTR_BITS-1:0]  count;
      logic [PTR_BITS-1:0]  n;
      int                   t;
      ans = '0;
      lg = (cap_log2_q > DEPTH_LOG2) ? CAPL_BITS'(DEPTH_LOG2) : cap_log2_q;
      room = PTR_BITS'(1) << lg;
      mask = room - 1'b1;
      count = head_ptr_q - tail_ptr_q - 1'b1;
      case (act)
         ACT_PUSH_HEAD: begin
            if (count < room) begin
               put_entry(head_ptr_q & mask, vin);
               head_ptr_q = head_ptr_q + 1'b1;
               ans.ok = 1'b1;
            end
         end
         ACT_POP_HEAD: begin
            if (count != 0) begin
               head_ptr_q = head_ptr_q - 1'b1;
               ans.value = entry_mem[DEPTH_LOG2'(head_ptr_q & mask)];
               ans.ok = 1'b1;
            end else begin
               ans.value = '1;
            end
         end
         ACT_PUSH_TAIL: begin
            if (count < room) begin
               put_entry(tail_ptr_q & mask, vin);
               tail_ptr_q = tail_ptr_q - 1'b1;
               ans.ok = 1'b1;
            end
         end
         ACT_POP_TAIL: begin
            if (count != 0) begin
               tail_ptr_q = tail_ptr_q + 1'b1;
               ans.value = entry_mem[DEPTH_LOG2'(tail_ptr_q & mask)];
               ans.ok = 1'b1;
            end else begin
               ans.value = '1;
            end
         end
         ACT_PEEK: begin
            ans.value = entry_mem[DEPTH_LOG2'(pidx & mask)];
            ans.ok = 1'b1;
         end
         ACT_REINIT: begin
            n = (prefill_q > room) ? room : PTR_BITS'(prefill_q);
            for (t = 0; t < int'(n); t++)
               put_entry(PTR_BITS'(t + 1) & mask, VALUE_BITS'(t));
            head_ptr_q = n + 1'b1;
            tail_ptr_q = '0;
            ans.ok = 1'b1;
         end
         default: ;
      endcase
      ans.fill = FILL_BITS'(head_ptr_q - tail_ptr_q - 1'b1);
   endtask

   always @(posedge clock) begin
      ring_answer_type want;
      ring_answer_type got;
      if (reset) begin
         head_ptr_q = PTR_BITS'(1);
         tail_ptr_q = '0;
         cap_log2_q = CAPL_BITS'(DEPTH_LOG2);
         prefill_q = '0;
         written_map = '0;
         pending_answers.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               REG_CAP_LOG2: cap_log2_q = csr_data[CAPL_BITS-1:0];
               REG_PREFILL:  prefill_q = csr_data[PRE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            apply_deque_op(req_tuser, req_tdata[VALUE_BITS-1:0],
                           req_tdata[VALUE_BITS +: PTR_BITS], want);
            pending_answers.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[VALUE_BITS-1:0];
            got.ok = rsp_tuser;
            got.fill = rsp_tdata[VALUE_BITS +: FILL_BITS];
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response value %h ok %0b fill %0d",
                        $time, got.value, got.ok, got.fill);
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  $display("%0t: expected value %h ok %0b fill %0d, got value %h ok %0b fill %0d",
                           $time, want.value, want.ok, want.fill,
                           got.value, got.ok, got.fill);
                  fail_count++;
               end
            end
         end
      end
      answers_due = pending_answers.size();
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import idr_pkg::*;

   localparam int IDLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CHUNK_ITEMS   = 46;
   localparam logic [ACT_BITS-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACT_BITS-1:0] ACT_SPARE_HI = 3'd7;

   localparam int SEND_IDLE_PCT [4] = '{0, 88, 0, 22};
   localparam int RECV_STALL_PCT[4] = '{0, 0, 88, 22};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_BITS-1:0]  req_tdata = '0;
   logic [ACT_BITS-1:0]  req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [RSP_BITS-1:0]  rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_addr = 1'b0;
   logic [CSR_BITS-1:0]  csr_data = '0;

   int                   fail_count;
   int                   answers_due;
   logic [DEPTH-1:0]     chk_written;
   logic [PTR_BITS-1:0]  chk_head;
   logic [PTR_BITS-1:0]  chk_tail;
   logic [CAPL_BITS-1:0] chk_cap_log2;

   int                   send_pct = 0;
   int                   stall_pct = 0;
   int                   quiet_cycles = 0;

   always #5 clock = ~clock;

   index_deque_ring u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   idr_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_addr    (csr_addr),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .answers_due (answers_due),
      .written_map (chk_written),
      .head_ptr_q  (chk_head),
      .tail_ptr_q  (chk_tail),
      .cap_log2_q  (chk_cap_log2)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [PTR_BITS-1:0] live_mask();
      logic [CAPL_BITS-1:0] lg;
      lg = (chk_cap_log2 > DEPTH_LOG2) ? CAPL_BITS'(DEPTH_LOG2) : chk_cap_log2;
      return (PTR_BITS'(1) << lg) - PTR_BITS'(1);
   endfunction

   // a read of a store entry never written is outside the contract
   function automatic bit reads_unwritten(input logic [ACT_BITS-1:0] act,
                                          input logic [PTR_BITS-1:0] pidx);
      logic [PTR_BITS-1:0] mask;
      logic [PTR_BITS-1:0] count;
      mask = live_mask();
      count = chk_head - chk_tail - 1'b1;
      case (act)
         ACT_POP_HEAD: return count != 0 && !chk_written[DEPTH_LOG2'((chk_head - 1'b1) & mask)];
         ACT_POP_TAIL: return count != 0 && !chk_written[DEPTH_LOG2'((chk_tail + 1'b1) & mask)];
         ACT_PEEK:     return !chk_written[DEPTH_LOG2'(pidx & mask)];
         default:      return 1'b0;
      endcase
   endfunction

   task automatic send_op(input logic [ACT_BITS-1:0] act, input logic [VALUE_BITS-1:0] vin,
                          input logic [PTR_BITS-1:0] pidx);
      logic [ACT_BITS-1:0] a;
      int                  gap;
      a = act;
      if (reads_unwritten(a, pidx))
         a = ACT_PUSH_HEAD;
      gap = 0;
      while ($urandom_range(99) < send_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {pidx, vin};
      req_tuser <= a;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [ACT_BITS-1:0]   act;
      logic [VALUE_BITS-1:0] vin;
      logic [PTR_BITS-1:0]   pidx;
      int                    pick;
      int                    k;
      pick = $urandom_range(99);
      if (pick < 22)
         act = ACT_PUSH_HEAD;
      else if (pick < 44)
         act = ACT_PUSH_TAIL;
      else if (pick < 62)
         act = ACT_POP_HEAD;
      else if (pick < 80)
         act = ACT_POP_TAIL;
      else if (pick < 93)
         act = ACT_PEEK;
      else if (pick < 97)
         act = ACT_REINIT;
      else
         act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      case ($urandom_range(7))
         0:       vin = '0;
         1:       vin = '1;
         default: vin = $urandom;
      endcase
      pidx = $urandom;
      if (act == ACT_PEEK) begin
         for (k = 0; k < 8 && reads_unwritten(act, pidx); k++)
            pidx = $urandom;
      end
      send_op(act, vin, pidx);
   endtask

   // hold off requests until every response is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (answers_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [CAPL_BITS-1:0] cap, input logic [PRE_BITS-1:0] pre);
      csr_addr <= REG_CAP_LOG2;
      csr_data <= CSR_BITS'({$urandom, cap});
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_addr <= REG_PREFILL;
      csr_data <= CSR_BITS'(pre);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int                   ph;
      int                   ch;
      int                   eff;
      logic [CAPL_BITS-1:0] cap;
      logic [PRE_BITS-1:0]  pre;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_config(4'd2, 11'd0);
      send_op(ACT_REINIT, '0, '0);
      send_op(ACT_PUSH_HEAD, '1, '0);
      send_op(ACT_PUSH_TAIL, '0, '1);
      send_op(ACT_PUSH_HEAD, 32'h1234_5678, '0);
      send_op(ACT_PUSH_TAIL, 32'h8000_0001, '0);
      send_op(ACT_PUSH_HEAD, 32'hdead_beef, '0);
      send_op(ACT_PUSH_TAIL, 32'hdead_beef, '0);
      send_op(ACT_PEEK, '0, '1);
      send_op(ACT_PEEK, '0, 32'h0000_0004);
      send_op(ACT_POP_HEAD, '0, '0);
      send_op(ACT_POP_TAIL, '0, '0);
      send_op(ACT_POP_HEAD, '0, '0);
      send_op(ACT_POP_TAIL, '0, '0);
      send_op(ACT_POP_HEAD, '0, '0);
      send_op(ACT_POP_TAIL, '0, '0);
      send_op(ACT_SPARE_LO, '1, '1);
      send_op(ACT_SPARE_HI, '1, '1);

      // widest capacity, prefill above it
      wait_drained();
      set_config(4'd15, 11'd2047);
      send_op(ACT_REINIT, '0, '0);
      send_op(ACT_PEEK, '0, '1);
      send_op(ACT_PUSH_HEAD, 32'h0f0f_0f0f, '0);
      send_op(ACT_POP_HEAD, '0, '0);

      // shrink capacity below the fill without reinit
      wait_drained();
      set_config(4'd1, 11'd5);
      send_op(ACT_PUSH_TAIL, 32'h5555_aaaa, '0);
      send_op(ACT_POP_TAIL, '0, '0);

      wait_drained();
      set_config(4'd0, 11'd3);
      send_op(ACT_REINIT, '0, '0);
      send_op(ACT_PUSH_HEAD, 32'haaaa_5555, '0);
      send_op(ACT_POP_TAIL, '0, '0);

      for (ph = 0; ph < 4; ph++) begin
         send_pct <= SEND_IDLE_PCT[ph];
         stall_pct <= RECV_STALL_PCT[ph];
         for (ch = 0; ch < 3; ch++) begin
            wait_drained();
            case ($urandom_range(9))
               0:       cap = '0;
               1:       cap = CAPL_BITS'(DEPTH_LOG2);
               2:       cap = CAPL_BITS'($urandom_range(11, 15));
               default: cap = CAPL_BITS'($urandom_range(1, 4));
            endcase
            eff = (cap > DEPTH_LOG2) ? DEPTH_LOG2 : int'(cap);
            case ($urandom_range(7))
               0:       pre = '0;
               1:       pre = '1;
               2:       pre = PRE_BITS'(DEPTH);
               default: pre = PRE_BITS'($urandom_range(0, 2 << eff));
            endcase
            set_config(cap, pre);
            if ($urandom_range(1))
               send_op(ACT_REINIT, $urandom, $urandom);
            repeat (CHUNK_ITEMS) send_random();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && answers_due == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
